// ===== sv/json_string_unescape_core_macros.svh =====
// ----------------------------------------------------------------------------
// json_string_unescape_core_macros
// Assertion helpers for the JSON string unescape core.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JSU_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("jsu: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define JSU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("jsu: next-cycle check failed");

`endif

// ===== sv/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and character constants of the JSON string unescape core.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int CHAR_W  = 8;
    localparam int CP_W    = 16;
    localparam int CNT_W   = 16;
    localparam int EVENT_W = 2;
    localparam int ERR_W   = 2;

    typedef enum logic [EVENT_W-1:0] {
        EV_CHAR  = 2'd0,
        EV_DONE  = 2'd1,
        EV_ERROR = 2'd2
    } event_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NOQUOTE = 2'd0,
        ERR_ESCAPE  = 2'd1,
        ERR_HEX     = 2'd2
    } err_t;

    // Parser modes, one-hot.
    typedef enum logic [6:0] {
        MODE_OPEN = 7'b0000001,
        MODE_BODY = 7'b0000010,
        MODE_ESC  = 7'b0000100,
        MODE_HEX4 = 7'b0001000,
        MODE_HEX3 = 7'b0010000,
        MODE_HEX2 = 7'b0100000,
        MODE_HEX1 = 7'b1000000
    } mode_t;

    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_B      = 8'h62;
    localparam logic [CHAR_W-1:0] CH_F      = 8'h66;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
    localparam logic [CHAR_W-1:0] CH_U      = 8'h75;
    localparam logic [CHAR_W-1:0] CH_BS_CTL = 8'h08;
    localparam logic [CHAR_W-1:0] CH_FF_CTL = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // Decode one ASCII hex digit; valid is low for anything else.
    function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
        hex_digit_t r;
        r.valid = 1'b1;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.value = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r.value = c[3:0] + 4'd9;
        end else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== sv/json_string_unescape_core.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_core: byte-wise JSON string decoder
// Output: registered; a result appears on m_* in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless a result stalls on m_tready; the single output register sets the pace.
// Reset: synchronous, active low; waits for an opening quote, counters at 0.
// ----------------------------------------------------------------------------
`include "json_string_unescape_core_macros.svh"

module json_string_unescape_core
    import jsu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [15:0] decoded_char, [17:16] error_code,
                                   // [33:18] line_number, [49:34] column_number,
                                   // [55:50] zero
    output logic [1:0]  m_tuser    // [1:0] event_res
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    mode_t              mode_reg,  mode_next;
    logic [CP_W-1:0]    acc_reg,   acc_next;
    logic [CNT_W-1:0]   line_reg,  line_next;
    logic [CNT_W-1:0]   col_reg,   col_next;

    // Output register: payload needs no reset, valid does.
    logic               out_valid_reg;
    event_t             out_event_reg, ev_next;
    logic [CP_W-1:0]    out_cp_reg,    cp_next;
    err_t               out_err_reg,   err_next;
    logic [CNT_W-1:0]   out_line_reg;
    logic [CNT_W-1:0]   out_col_reg;

    logic               emit_next;
    logic               in_accept;
    logic               err_taken;
    logic [CHAR_W-1:0]  c;
    hex_digit_t         hd;
    logic [CP_W-1:0]    acc_shift;

    // Take a new request whenever the result register is free or draining.
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign c         = s_tdata;
    assign hd        = hex_decode(c);
    assign acc_shift = {acc_reg[CP_W-5:0], hd.value};
    assign err_taken = in_accept && emit_next && (ev_next == EV_ERROR);

    // ------------------------------------------------------------------
    // Location counters: updated for every byte before decode.
    // A newline bumps the line (saturating) and clears the column.
    // ------------------------------------------------------------------
    always_comb begin
        if (c == CH_LF) begin
            line_next = (line_reg == CNT_MAX) ? line_reg : line_reg + 1'b1;
            col_next  = '0;
        end else begin
            line_next = line_reg;
            col_next  = (col_reg == CNT_MAX) ? col_reg : col_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Decode: one pass over the current byte and mode.
    // ------------------------------------------------------------------
    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        emit_next = 1'b0;
        ev_next   = EV_CHAR;
        cp_next   = '0;
        err_next  = ERR_NOQUOTE;
        unique case (mode_reg)
            MODE_BODY: begin
                if (c == CH_BSLASH) begin
                    mode_next = MODE_ESC;
                end else if (c == CH_QUOTE) begin
                    // Closing quote: report completion and rearm.
                    mode_next = MODE_OPEN;
                    emit_next = 1'b1;
                    ev_next   = EV_DONE;
                end else begin
                    // Plain byte, including raw control bytes.
                    emit_next = 1'b1;
                    cp_next   = {{(CP_W-CHAR_W){1'b0}}, c};
                end
            end
            MODE_ESC: begin
                emit_next = 1'b1;
                mode_next = MODE_BODY;
                unique case (c)
                    CH_QUOTE, CH_BSLASH, CH_SLASH:
                         cp_next = {{(CP_W-CHAR_W){1'b0}}, c};
                    CH_B: cp_next = {{(CP_W-CHAR_W){1'b0}}, CH_BS_CTL};
                    CH_F: cp_next = {{(CP_W-CHAR_W){1'b0}}, CH_FF_CTL};
                    CH_N: cp_next = {{(CP_W-CHAR_W){1'b0}}, CH_LF};
                    CH_T: cp_next = {{(CP_W-CHAR_W){1'b0}}, CH_TAB};
                    CH_U: begin
                        // Start a \u sequence: clear the accumulator.
                        emit_next = 1'b0;
                        acc_next  = '0;
                        mode_next = MODE_HEX4;
                    end
                    default: begin
                        // Unknown escape letter (\r among them).
                        mode_next = MODE_OPEN;
                        ev_next   = EV_ERROR;
                        err_next  = ERR_ESCAPE;
                    end
                endcase
            end
            MODE_HEX4, MODE_HEX3, MODE_HEX2, MODE_HEX1: begin
                if (!hd.valid) begin
                    mode_next = MODE_OPEN;
                    emit_next = 1'b1;
                    ev_next   = EV_ERROR;
                    err_next  = ERR_HEX;
                end else begin
                    acc_next = acc_shift;
                    unique case (mode_reg)
                        MODE_HEX4: mode_next = MODE_HEX3;
                        MODE_HEX3: mode_next = MODE_HEX2;
                        MODE_HEX2: mode_next = MODE_HEX1;
                        default: begin
                            // Last digit: emit the assembled code point.
                            mode_next = MODE_BODY;
                            emit_next = 1'b1;
                            cp_next   = acc_shift;
                        end
                    endcase
                end
            end
            default: begin
                // Waiting for the opening quote; anything else is an error.
                if (c == CH_QUOTE) begin
                    mode_next = MODE_BODY;
                end else begin
                    mode_next = MODE_OPEN;
                    emit_next = 1'b1;
                    ev_next   = EV_ERROR;
                    err_next  = ERR_NOQUOTE;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Parser state and counters: advance on every accepted byte.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_OPEN;
            acc_reg  <= '0;
            line_reg <= '0;
            col_reg  <= '0;
        end else if (in_accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: load when a byte produces a result, drop when taken.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_accept) begin
            out_valid_reg <= emit_next;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && emit_next) begin
            out_event_reg <= ev_next;
            out_cp_reg    <= cp_next;
            out_err_reg   <= err_next;
            out_line_reg  <= line_next;
            out_col_reg   <= col_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_event_reg;
    assign m_tdata  = {6'd0, out_col_reg, out_line_reg, out_err_reg, out_cp_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A stalled result register must hold off new bytes.
    `JSU_ASSERT_SAME(a_stall_blocks_input, aclk, aresetn, !s_tready, m_tvalid)
    // Any error rearms the parser to wait for an opening quote.
    `JSU_ASSERT_NEXT(a_error_rearms, aclk, aresetn, err_taken, mode_reg == MODE_OPEN)
    // A newline clears the column counter.
    `JSU_ASSERT_NEXT(a_newline_clears_col, aclk, aresetn, in_accept && s_tdata == CH_LF, col_reg == '0)

endmodule
